// ----- sv/pse_pkg.sv -----
`default_nettype none

package pse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int DIV_STEPS   = WORD_W;
	localparam int STEP_W      = $clog2(DIV_STEPS + 1);

	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;
	localparam logic [7:0] SYM_ZERO = 8'h30;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_FULL      = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              div_zero;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/pse_ram.sv -----
`default_nettype none

module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/pse_div.sv -----
`default_nettype none

module pse_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pse_pkg::div_req_t req,
	output pse_pkg::div_rsp_t      rsp
);

	import pse_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] den_q;
	logic              neg_q;
	logic              zero_q;
	logic              done_q;
	logic [WORD_W-1:0] result_q;

	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;
	logic              fits;

	assign mag_a   = req.dividend[WORD_W-1] ? (WORD_W'(0) - req.dividend) : req.dividend;
	assign mag_b   = req.divisor[WORD_W-1] ? (WORD_W'(0) - req.divisor) : req.divisor;
	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = !diff[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(DIV_STEPS));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == STEP_W'(DIV_STEPS)) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + STEP_W'(1);
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle, sign fixed in the final cycle
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q  <= '0;
			quo_q  <= mag_a;
			den_q  <= mag_b;
			neg_q  <= req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
			zero_q <= (mag_b == '0);
		end else if (busy_q) begin
			if (cnt_q == STEP_W'(DIV_STEPS)) begin
				if (zero_q) begin
					result_q <= '0;
				end else if (neg_q) begin
					result_q <= WORD_W'(0) - quo_q;
				end else begin
					result_q <= quo_q;
				end
			end else begin
				rem_q <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], fits};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = zero_q;
	assign rsp.quotient = result_q;

endmodule

`default_nettype wire

// ----- sv/postfix_stack_evaluator.sv -----
// Per request: an operand passes through S_PUSH; + - * through S_EXEC and S_PUSH; /
// through S_EXEC, S_DIV (serial divider, one quotient bit per cycle) and S_PUSH. A
// request marked last adds S_EMIT, which waits while out_valid is up and out_ready low,
// before the result reaches the output register. One request is in flight at a time.
// Reset (arst_n low, asynchronous) empties the stack, clears the error code and out_valid;
// stack memory contents are not cleared, entries at or above the count are never used.
`default_nettype none

module postfix_stack_evaluator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  symbol,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] value,
	output logic [2:0]       status
);

	import pse_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_DIV  = 5'b00100,
		S_PUSH = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	status_t           err_q;
	logic [7:0]        sym_q;
	logic              last_q;
	logic              op_q;
	logic [WORD_W-1:0] top_q;
	logic [WORD_W-1:0] res_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] value_q;
	logic [2:0]        status_q;

	logic              accept;
	logic              is_op;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] left;
	logic [WORD_W-1:0] right;
	logic              short;
	logic [WORD_W-1:0] push_val;
	logic              full;
	logic              emit_fire;
	logic              ram_we;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_op     = (symbol == SYM_ADD) || (symbol == SYM_SUB) ||
	                   (symbol == SYM_MUL) || (symbol == SYM_DIV);

	// right operand is the cached top, left is read from memory at count-2
	assign right     = (count_q >= CNT_W'(1)) ? top_q : '1;
	assign left      = (count_q >= CNT_W'(2)) ? rd_data : '1;
	assign short     = (count_q < CNT_W'(2));
	assign push_val  = op_q ? res_q : ({24'b0, sym_q} - {24'b0, SYM_ZERO});
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign ram_we    = (state_q == S_PUSH) && !full;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	assign div_req.start    = (state_q == S_EXEC) && (sym_q == SYM_DIV);
	assign div_req.dividend = left;
	assign div_req.divisor  = right;

	pse_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (push_val),
		.re    (accept),
		.raddr (ADDR_W'(count_q - CNT_W'(2))),
		.rdata (rd_data)
	);

	pse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= is_op ? S_EXEC : S_PUSH;
					end
				end
				S_EXEC: begin
					if (short && err_q == ST_OK) begin
						err_q <= ST_UNDERFLOW;
					end
					count_q <= short ? '0 : (count_q - CNT_W'(2));
					state_q <= (sym_q == SYM_DIV) ? S_DIV : S_PUSH;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (div_rsp.div_zero && err_q == ST_OK) begin
							err_q <= ST_DIVZERO;
						end
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (full) begin
						if (err_q == ST_OK) begin
							err_q <= ST_FULL;
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit_fire) begin
						count_q <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= symbol;
			last_q <= last;
			op_q   <= is_op;
		end
		if (state_q == S_EXEC) begin
			case (sym_q)
				SYM_ADD: res_q <= left + right;
				SYM_SUB: res_q <= left - right;
				SYM_MUL: res_q <= left * right;
				default: res_q <= '0;
			endcase
		end
		if (state_q == S_DIV && div_rsp.done) begin
			res_q <= div_rsp.quotient;
		end
		if (ram_we) begin
			top_q <= push_val;
		end
		if (emit_fire) begin
			value_q <= (count_q != '0) ? top_q : '0;
			if (err_q != ST_OK) begin
				status_q <= err_q;
			end else if (count_q == '0) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> (count_q == '0) && (err_q == ST_OK) && out_valid_q)
		else $error("stack or status not cleared after result");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide wait");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= 3'd4))
		else $error("status code out of range");

endmodule

`default_nettype wire
